// File: sv/cbt_pkg.sv
`timescale 1ns / 1ps

package cbt_pkg;

  localparam int unsigned MAX_SUBDIV = 16;
  localparam int unsigned NW         = 5;   // subdivision count / point index width
  localparam int unsigned FRAC       = 16;  // Q16.16 fraction bits
  localparam int unsigned TW         = FRAC + 1;  // t reaches 1.0 on the end point
  localparam int unsigned CW         = 38;  // coefficient / accumulator width
  localparam int unsigned PW         = CW + TW + 1;  // product width
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QAW        = 1;
  localparam int unsigned QCW        = 2;
  localparam int unsigned HLAT       = 6;   // evaluator pipeline depth

  localparam logic [NW-1:0] SUBDIV_RST = NW'(5);
  localparam logic [NW-1:0] SUBDIV_MAX = NW'(MAX_SUBDIV);
  localparam logic [TW-1:0] ONE_Q16    = TW'(1) << FRAC;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] ctrl_a_x;
    logic signed [31:0] ctrl_a_y;
    logic signed [31:0] ctrl_a_z;
    logic signed [31:0] ctrl_b_x;
    logic signed [31:0] ctrl_b_y;
    logic signed [31:0] ctrl_b_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } req_t;

  typedef struct packed {
    logic [NW-1:0]      point_number;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [31:0]   p0;
  } axis_coef_t;

  typedef struct packed {
    axis_coef_t    ax;
    axis_coef_t    ay;
    axis_coef_t    az;
    logic [NW-1:0] n;
  } seg_t;

  typedef struct packed {
    logic [TW-1:0] q;
    logic [NW-1:0] r;
  } tstep_t;

  // floor(65536/n) and 65536 mod n, per subdivision count
  function automatic tstep_t tstep_lookup(input logic [NW-1:0] n);
    tstep_t s;
    case (n)
      NW'(2):  s = '{q: TW'(32768), r: NW'(0)};
      NW'(3):  s = '{q: TW'(21845), r: NW'(1)};
      NW'(4):  s = '{q: TW'(16384), r: NW'(0)};
      NW'(5):  s = '{q: TW'(13107), r: NW'(1)};
      NW'(6):  s = '{q: TW'(10922), r: NW'(4)};
      NW'(7):  s = '{q: TW'(9362),  r: NW'(2)};
      NW'(8):  s = '{q: TW'(8192),  r: NW'(0)};
      NW'(9):  s = '{q: TW'(7281),  r: NW'(7)};
      NW'(10): s = '{q: TW'(6553),  r: NW'(6)};
      NW'(11): s = '{q: TW'(5957),  r: NW'(9)};
      NW'(12): s = '{q: TW'(5461),  r: NW'(4)};
      NW'(13): s = '{q: TW'(5041),  r: NW'(3)};
      NW'(14): s = '{q: TW'(4681),  r: NW'(2)};
      NW'(15): s = '{q: TW'(4369),  r: NW'(1)};
      NW'(16): s = '{q: TW'(4096),  r: NW'(0)};
      default: s = '{q: ONE_Q16,    r: NW'(0)};
    endcase
    return s;
  endfunction

endpackage

// File: sv/cbt_front.sv
`timescale 1ns / 1ps

module cbt_front import cbt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [NW-1:0] cfg_data_i,
  input  logic          start,
  input  logic          full_i,
  input  req_t          req_i,
  output logic          push_o,
  output seg_t          seg_o
);

  logic [NW-1:0] subdiv_q, subdiv_d;
  logic [NW-1:0] cfg_v;

  assign cfg_ready_o = 1'b1;
  assign cfg_v       = (cfg_data_i == '0) ? NW'(1) : cfg_data_i;

  always_comb begin
    subdiv_d = subdiv_q;
    if (cfg_valid_i && cfg_v <= SUBDIV_MAX) begin
      subdiv_d = cfg_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= SUBDIV_RST;
    end else begin
      subdiv_q <= subdiv_d;
    end
  end

  function automatic axis_coef_t axis_coef(input logic signed [31:0] p0,
                                           input logic signed [31:0] p1,
                                           input logic signed [31:0] p2,
                                           input logic signed [31:0] p3);
    axis_coef_t r;
    logic signed [CW-1:0] e0, e1, e2, e3, d10, d21;
    e0  = CW'(p0);
    e1  = CW'(p1);
    e2  = CW'(p2);
    e3  = CW'(p3);
    d10 = e1 - e0;
    d21 = e2 - e1;
    r.c  = (d10 <<< 1) + d10;
    r.b  = (d21 <<< 1) + d21 - r.c;
    r.a  = e3 - e0 - r.c - r.b;
    r.p0 = p0;
    return r;
  endfunction

  assign push_o   = start && !full_i;
  assign seg_o.ax = axis_coef(req_i.start_x, req_i.ctrl_a_x, req_i.ctrl_b_x, req_i.end_x);
  assign seg_o.ay = axis_coef(req_i.start_y, req_i.ctrl_a_y, req_i.ctrl_b_y, req_i.end_y);
  assign seg_o.az = axis_coef(req_i.start_z, req_i.ctrl_a_z, req_i.ctrl_b_z, req_i.end_z);
  assign seg_o.n  = subdiv_q;

endmodule

// File: sv/cbt_queue.sv
`timescale 1ns / 1ps

module cbt_queue import cbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  seg_t data_i,
  input  logic pop_i,
  output seg_t data_o,
  output logic valid_o,
  output logic full_o
);

  seg_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCW-1:0] count_q, count_d;

  assign data_o  = mem_q[rd_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCW'(QDEPTH));

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full segment queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty segment queue");

endmodule

// File: sv/cbt_horner.sv
`timescale 1ns / 1ps

module cbt_horner import cbt_pkg::*; (
  input  logic               clk_i,
  input  axis_coef_t         coef_i,
  input  logic [TW-1:0]      t_i,
  output logic signed [31:0] res_o
);

  // six stages: mul, add, mul, add, mul, add+saturate
  logic signed [PW-1:0] pr1_q, pr2_q, pr3_q;
  logic signed [CW-1:0] ac1_q, ac2_q;
  logic signed [CW-1:0] b1_q, c1_q, c2_q, c3_q;
  logic signed [31:0]   p01_q, p02_q, p03_q, p04_q, p05_q;
  logic [TW-1:0]        t1_q, t2_q, t3_q, t4_q;
  logic signed [31:0]   res_q;
  logic signed [CW-1:0] sum3;
  logic signed [TW:0]   ts_in, ts2, ts4;

  assign ts_in = $signed({1'b0, t_i});
  assign ts2   = $signed({1'b0, t2_q});
  assign ts4   = $signed({1'b0, t4_q});

  // the part-select of the product is the floor shift, the value stays within CW
  assign sum3 = $signed(pr3_q[CW+FRAC-1:FRAC]) + CW'(p05_q);

  always_ff @(posedge clk_i) begin
    pr1_q <= coef_i.a * ts_in;
    b1_q  <= coef_i.b;
    c1_q  <= coef_i.c;
    p01_q <= coef_i.p0;
    t1_q  <= t_i;

    ac1_q <= $signed(pr1_q[CW+FRAC-1:FRAC]) + b1_q;
    c2_q  <= c1_q;
    p02_q <= p01_q;
    t2_q  <= t1_q;

    pr2_q <= ac1_q * ts2;
    c3_q  <= c2_q;
    p03_q <= p02_q;
    t3_q  <= t2_q;

    ac2_q <= $signed(pr2_q[CW+FRAC-1:FRAC]) + c3_q;
    p04_q <= p03_q;
    t4_q  <= t3_q;

    pr3_q <= ac2_q * ts4;
    p05_q <= p04_q;

    if (sum3[CW-1:31] == '0 || sum3[CW-1:31] == '1) begin
      res_q <= sum3[31:0];
    end else if (sum3[CW-1]) begin
      res_q <= 32'sh8000_0000;
    end else begin
      res_q <= 32'sh7fff_ffff;
    end
  end

  assign res_o = res_q;

endmodule

// File: sv/cbt_back.sv
`timescale 1ns / 1ps

module cbt_back import cbt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   head_valid_i,
  input  seg_t   head_i,
  output logic   pop_o,
  output logic   point_valid_o,
  output point_t point_o
);

  logic          act_q, act_d;
  logic [NW-1:0] idx_q, idx_d, n_q, n_d, rem_q, rem_d;
  logic [TW-1:0] t_q, t_d;
  tstep_t        step_q, step_d;
  seg_t          seg_q;
  logic          at_end;
  logic [NW-1:0] rsum;

  logic          vld_q  [HLAT];
  logic [NW-1:0] num_q  [HLAT];
  logic          last_q [HLAT];

  assign at_end = (idx_q == n_q);
  assign pop_o  = head_valid_i && (!act_q || at_end);
  assign rsum   = rem_q + step_q.r;

  always_comb begin
    act_d  = act_q;
    idx_d  = idx_q;
    n_d    = n_q;
    rem_d  = rem_q;
    t_d    = t_q;
    step_d = step_q;
    if (pop_o) begin
      act_d  = 1'b1;
      idx_d  = '0;
      n_d    = head_i.n;
      rem_d  = '0;
      t_d    = '0;
      step_d = tstep_lookup(head_i.n);
    end else if (act_q && at_end) begin
      act_d = 1'b0;
    end else if (act_q) begin
      idx_d = idx_q + 1'b1;
      // t = floor(i*65536/n) kept exact by carrying the remainder
      if (rsum >= n_q) begin
        rem_d = rsum - n_q;
        t_d   = t_q + step_q.q + 1'b1;
      end else begin
        rem_d = rsum;
        t_d   = t_q + step_q.q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      for (int k = 0; k < HLAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      act_q    <= act_d;
      vld_q[0] <= act_q;
      for (int k = 1; k < HLAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    n_q       <= n_d;
    rem_q     <= rem_d;
    t_q       <= t_d;
    step_q    <= step_d;
    num_q[0]  <= idx_q;
    last_q[0] <= at_end;
    for (int k = 1; k < HLAT; k++) begin
      num_q[k]  <= num_q[k-1];
      last_q[k] <= last_q[k-1];
    end
    if (pop_o) begin
      seg_q <= head_i;
    end
  end

  // t = 0 gives p0 and t = 1.0 gives p3 exactly, so the end points need no bypass
  cbt_horner u_hx (.clk_i, .coef_i(seg_q.ax), .t_i(t_q), .res_o(point_o.point_x));
  cbt_horner u_hy (.clk_i, .coef_i(seg_q.ay), .t_i(t_q), .res_o(point_o.point_y));
  cbt_horner u_hz (.clk_i, .coef_i(seg_q.az), .t_i(t_q), .res_o(point_o.point_z));

  assign point_valid_o        = vld_q[HLAT-1];
  assign point_o.point_number = num_q[HLAT-1];
  assign point_o.last_point   = last_q[HLAT-1];

  a_t_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (t_q <= ONE_Q16)) else $error("t beyond 1.0");

  a_end_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && at_end) |-> (t_q == ONE_Q16)) else $error("end point t is not 1.0");

  a_seq_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_valid_o && !point_o.last_point) |=>
      (point_valid_o && point_o.point_number == NW'($past(point_o.point_number) + 1'b1)))
    else $error("gap inside a segment");

  a_seq_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_valid_o && point_o.last_point) |=>
      (!point_valid_o || point_o.point_number == '0))
    else $error("segment does not restart at point 0");

endmodule

// File: sv/cubic_bezier_tessellator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             req_i (four Q16.16 control points)
// point     out        point_valid_o, 1 cycle    point_o (index, x, y, z, last flag)
// config    in         cfg_valid_i & cfg_ready_o cfg_data_i (subdivisions)
//
// A segment gives subdivisions+1 points, one per cycle from the sequencer;
// segments follow back to back while the next one waits in the queue.
// The six-stage Horner pipeline per axis (three 38x18 multiplies) follows the sequencer.
// busy is high while the two-entry segment queue is full.
// Reset clears the control state and sets subdivisions to 5.
// Points cannot be stalled; cfg_ready_o is always high.

module cubic_bezier_tessellator import cbt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  req_t          req_i,
  output logic          point_valid_o,
  output point_t        point_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [NW-1:0] cfg_data_i
);

  logic push, pop, full, head_valid;
  seg_t seg_in, seg_head;

  assign busy = full;

  cbt_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .start,
    .full_i (full),
    .req_i,
    .push_o (push),
    .seg_o  (seg_in)
  );

  cbt_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (seg_in),
    .pop_i   (pop),
    .data_o  (seg_head),
    .valid_o (head_valid),
    .full_o  (full)
  );

  cbt_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (seg_head),
    .pop_o        (pop),
    .point_valid_o,
    .point_o
  );

endmodule

// File: tb/tb_cubic_bezier_tessellator.sv
`timescale 1ns / 1ps

module tb_cubic_bezier_tessellator;
  import cbt_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start       = 1'b0;
  logic          busy;
  req_t          req_i       = '0;
  logic          point_valid_o;
  point_t        point_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [NW-1:0] cfg_data_i  = '0;

  point_t      pending_points[$];
  int unsigned subdiv_model = SUBDIV_RST;
  int unsigned req_idle_pct = 0;
  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;

  cubic_bezier_tessellator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .point_valid_o(point_valid_o),
    .point_o      (point_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Horner evaluation of one axis, floor shifts, clamp to Q16.16
  function automatic logic signed [31:0] curve_axis(longint p0, longint p1, longint p2,
                                                   longint p3, longint t);
    longint c, b, a, acc;
    c   = 3 * (p1 - p0);
    b   = 3 * (p2 - p1) - c;
    a   = p3 - p0 - c - b;
    acc = ((a * t) >>> FRAC) + b;
    acc = ((acc * t) >>> FRAC) + c;
    acc = ((acc * t) >>> FRAC) + p0;
    if (acc > longint'(Q_MAX)) return Q_MAX;
    if (acc < longint'(Q_MIN)) return Q_MIN;
    return acc[31:0];
  endfunction

  function automatic void queue_segment_points(req_t r);
    point_t pt;
    longint t;
    for (int unsigned i = 0; i <= subdiv_model; i++) begin
      pt.point_number = NW'(i);
      pt.last_point   = (i == subdiv_model);
      if (i == 0) begin
        pt.point_x = r.start_x;
        pt.point_y = r.start_y;
        pt.point_z = r.start_z;
      end else if (i == subdiv_model) begin
        pt.point_x = r.end_x;
        pt.point_y = r.end_y;
        pt.point_z = r.end_z;
      end else begin
        t = longint'((i * 65536) / subdiv_model);
        pt.point_x = curve_axis(r.start_x, r.ctrl_a_x, r.ctrl_b_x, r.end_x, t);
        pt.point_y = curve_axis(r.start_y, r.ctrl_a_y, r.ctrl_b_y, r.end_y, t);
        pt.point_z = curve_axis(r.start_z, r.ctrl_a_z, r.ctrl_b_z, r.end_z, t);
      end
      pending_points.push_back(pt);
    end
  endfunction

  function automatic req_t uniform_req(logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                                       logic [31:0] p3);
    req_t r;
    r = {p0, p0, p0, p1, p1, p1, p2, p2, p2, p3, p3, p3};
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    logic [31:0] w[12];
    int unsigned kind;
    int          base;
    kind = $urandom_range(0, 9);
    for (int ax = 0; ax < 3; ax++) begin
      // kind per request, center per axis: random words, rail values, near a rail, or a local curve
      base = int'($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      for (int p = 0; p < 4; p++) begin
        case (kind)
          0, 1: w[p*3+ax] = $urandom;
          2: begin
            case ($urandom_range(0, 3))
              0: w[p*3+ax] = Q_MIN;
              1: w[p*3+ax] = Q_MAX;
              2: w[p*3+ax] = '0;
              default: w[p*3+ax] = '1;
            endcase
          end
          3: w[p*3+ax] = Q_MIN + int'($urandom_range(0, 255));
          4: w[p*3+ax] = Q_MAX - int'($urandom_range(0, 255));
          default: w[p*3+ax] = base + int'($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
        endcase
      end
    end
    for (int k = 0; k < 12; k++) r[$bits(req_t)-1-32*k -: 32] = w[k];
    return r;
  endfunction

  // leaves start high so that back-to-back requests need no extra edge
  task automatic send_segment(req_t r);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    queue_segment_points(r);
  endtask

  task automatic drain_points();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_subdivisions(logic [NW-1:0] v);
    drain_points();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (v == 0) subdiv_model = 1;
    else if (v <= SUBDIV_MAX) subdiv_model = v;
  endtask

  always @(posedge clk_i) begin : check_points
    point_t want;
    if (rst_ni && point_valid_o) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point, point_number %0d", point_o.point_number);
        err_count++;
      end else begin
        want = pending_points.pop_front();
        if (point_o.point_number !== want.point_number) begin
          $error("point_number expected %0d got %0d", want.point_number, point_o.point_number);
          err_count++;
        end
        if (point_o.point_x !== want.point_x) begin
          $error("point_x expected %0d got %0d", want.point_x, point_o.point_x);
          err_count++;
        end
        if (point_o.point_y !== want.point_y) begin
          $error("point_y expected %0d got %0d", want.point_y, point_o.point_y);
          err_count++;
        end
        if (point_o.point_z !== want.point_z) begin
          $error("point_z expected %0d got %0d", want.point_z, point_o.point_z);
          err_count++;
        end
        if (point_o.last_point !== want.last_point) begin
          $error("last_point expected %0d got %0d", want.last_point, point_o.last_point);
          err_count++;
        end
      end
    end
  end

  // no config write: reset count of five applies
  task automatic test_default_subdivisions();
    send_segment(uniform_req('0, '0, '0, '0));
    send_segment(uniform_req('0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE));
    send_segment(uniform_req(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_segment(uniform_req(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_segment(uniform_req(Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_segment(random_req());
  endtask

  task automatic test_subdivision_register();
    set_subdivisions(NW'(0));   // zero becomes one: endpoints only
    send_segment(uniform_req(Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_segment(random_req());
    set_subdivisions(SUBDIV_MAX);
    send_segment(uniform_req(Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_segment(random_req());
    set_subdivisions(NW'(SUBDIV_MAX + 1));  // ignored
    send_segment(random_req());
    set_subdivisions('1);              // ignored
    send_segment(uniform_req(Q_MAX, Q_MIN, Q_MIN, Q_MAX));
    set_subdivisions(NW'(1));
    send_segment(random_req());
    set_subdivisions(NW'(2));
    send_segment(random_req());
    set_subdivisions(NW'(3));
    send_segment(random_req());
  endtask

  // curves pinned to the rails: floor shifts may cross the lower limit
  task automatic test_rail_clamp();
    set_subdivisions(NW'(7));
    send_segment(uniform_req(Q_MIN, Q_MIN + 5, Q_MIN, Q_MIN + 1));
    send_segment(uniform_req(Q_MIN + 1, Q_MIN, Q_MIN + 3, Q_MIN));
    send_segment(uniform_req(Q_MAX, Q_MAX - 3, Q_MAX, Q_MAX - 1));
  endtask

  task automatic test_random_segments();
    int unsigned idle_pct[3] = '{12, 64, 0};
    for (int ph = 0; ph < 3; ph++) begin
      req_idle_pct = idle_pct[ph];
      repeat (6) begin
        if ($urandom_range(0, 9) == 0) set_subdivisions(NW'($urandom_range(0, 31)));
        else set_subdivisions(NW'($urandom_range(1, MAX_SUBDIV)));
        repeat (15) send_segment(random_req());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_subdivisions();
    test_subdivision_register();
    test_rail_clamp();
    test_random_segments();
    drain_points();
    repeat (3 * HLAT + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cbt_pkg.sv
sv/cbt_front.sv
sv/cbt_queue.sv
sv/cbt_horner.sv
sv/cbt_back.sv
sv/cubic_bezier_tessellator.sv
tb/tb_cubic_bezier_tessellator.sv
